FILE: rtl/tsa_pkg.sv
// tsa_pkg: shared codes, field widths and parameter defaults for the TLB slot allocator.
// No dependencies; imported by every module of the block.
package tsa_pkg;

  // Field widths fixed by the item format
  localparam int REQ_W     = 2;
  localparam int SLOT_W    = 6;
  localparam int OUTCOME_W = 3;

  // Parameter defaults
  localparam int DEF_ENTRIES          = 64;
  localparam int DEF_PAGE_NUMBER_BITS = 20;

  // Request codes (a set high bit always means flush)
  localparam logic [REQ_W-1:0] REQ_ADD   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_INVAL = 2'd1;

  // Outcome codes
  localparam logic [OUTCOME_W-1:0] OUT_ADD_FREE   = 3'd0;
  localparam logic [OUTCOME_W-1:0] OUT_ADD_REPL   = 3'd1;
  localparam logic [OUTCOME_W-1:0] OUT_INVAL_HIT  = 3'd2;
  localparam logic [OUTCOME_W-1:0] OUT_INVAL_MISS = 3'd3;
  localparam logic [OUTCOME_W-1:0] OUT_FLUSHED    = 3'd4;

  // Commands from the control logic to the free list
  typedef struct packed {
    logic pop;
    logic push;
    logic flush;
  } fl_cmd_t;

endpackage

FILE: rtl/tsa_cam.sv
// tsa_cam: entry storage of the TLB with a parallel virtual page match and
// lowest-slot priority select. Depends on tsa_pkg.
module tsa_cam import tsa_pkg::*; #(
  parameter int ENTRIES          = DEF_ENTRIES,
  parameter int PAGE_NUMBER_BITS = DEF_PAGE_NUMBER_BITS,
  localparam int IW              = $clog2(ENTRIES)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // lookup
  input  logic [PAGE_NUMBER_BITS-1:0] lookup_vpage,
  output logic                        hit,
  output logic [IW-1:0]               hit_idx,
  // fill
  input  logic                        wr_en,
  input  logic [IW-1:0]               wr_idx,
  input  logic [PAGE_NUMBER_BITS-1:0] wr_vpage,
  input  logic [PAGE_NUMBER_BITS-1:0] wr_ppage,
  input  logic                        wr_dirty,
  // invalidate one slot / all slots
  input  logic                        clr_en,
  input  logic [IW-1:0]               clr_idx,
  input  logic                        flush
);

  logic [PAGE_NUMBER_BITS-1:0] vpage_r [ENTRIES];
  logic [PAGE_NUMBER_BITS-1:0] ppage_r [ENTRIES];
  logic                        dirty_r [ENTRIES];
  logic [ENTRIES-1:0]          valid_r;
  logic [ENTRIES-1:0]          valid_nxt;

  logic [ENTRIES-1:0] match;
  logic [ENTRIES-1:0] lowest;

  // Compare every valid entry against the page
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      match[i] = valid_r[i] && (vpage_r[i] == lookup_vpage);
    end
  end

  // Isolate the lowest matching slot, then encode it
  assign lowest = match & (~match + {{(ENTRIES-1){1'b0}}, 1'b1});
  assign hit    = |match;

  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (lowest[i]) begin
        hit_idx = hit_idx | IW'(i);
      end
    end
  end

  // Valid bits
  always_comb begin
    valid_nxt = valid_r;
    if (flush) begin
      valid_nxt = '0;
    end else if (wr_en) begin
      valid_nxt[wr_idx] = 1'b1;
    end else if (clr_en) begin
      valid_nxt[clr_idx] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Entry payload; an invalid entry is never matched, so no reset
  always_ff @(posedge clk) begin
    if (wr_en && !flush) begin
      vpage_r[wr_idx] <= wr_vpage;
      ppage_r[wr_idx] <= wr_ppage;
      dirty_r[wr_idx] <= wr_dirty;
    end
  end

endmodule

FILE: rtl/tsa_free_list.sv
// tsa_free_list: free slot list kept as a stack of released slots on top of a
// run of never-used slots counted upward. Depends on tsa_pkg.
module tsa_free_list import tsa_pkg::*; #(
  parameter int ENTRIES = DEF_ENTRIES,
  localparam int IW     = $clog2(ENTRIES),
  localparam int CW     = $clog2(ENTRIES + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  fl_cmd_t       cmd,
  input  logic [IW-1:0] push_slot,
  output logic          nonempty,
  output logic [IW-1:0] head
);

  localparam int DEPTH = 1 << IW;

  // Stack: top_r holds the newest released slot, mem holds the ones below it,
  // below_r is a registered copy of the entry just under the top.
  logic [IW-1:0] mem [DEPTH];
  logic [CW-1:0] cnt_r,   cnt_nxt;
  logic [CW-1:0] fresh_r, fresh_nxt;
  logic [IW-1:0] top_r,   top_nxt;
  logic [IW-1:0] below_r;

  logic          we;
  logic [IW-1:0] waddr;
  logic [IW-1:0] raddr;
  logic [CW-1:0] cnt_m1;
  logic [CW-1:0] raddr_w;

  assign nonempty = (cnt_r != '0) || (fresh_r != CW'(ENTRIES));
  assign head     = (cnt_r != '0) ? top_r : fresh_r[IW-1:0];
  assign cnt_m1   = cnt_r - CW'(1);

  // Head update
  always_comb begin
    cnt_nxt   = cnt_r;
    fresh_nxt = fresh_r;
    top_nxt   = top_r;
    we        = 1'b0;
    waddr     = cnt_m1[IW-1:0];
    if (cmd.flush) begin
      cnt_nxt   = '0;
      fresh_nxt = '0;
    end else if (cmd.pop) begin
      if (cnt_r != '0) begin
        top_nxt = below_r;
        cnt_nxt = cnt_m1;
      end else begin
        fresh_nxt = fresh_r + CW'(1);
      end
    end else if (cmd.push) begin
      we      = (cnt_r != '0);
      top_nxt = push_slot;
      cnt_nxt = cnt_r + CW'(1);
    end
  end

  // Fetch the entry that will sit under the new top
  assign raddr_w = cnt_nxt - CW'(2);
  assign raddr   = raddr_w[IW-1:0];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= top_r;
    end
    below_r <= (we && (waddr == raddr)) ? top_r : mem[raddr];
  end

  always_ff @(posedge clk) begin
    top_r <= top_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      fresh_r <= '0;
    end else begin
      cnt_r   <= cnt_nxt;
      fresh_r <= fresh_nxt;
    end
  end

endmodule

FILE: rtl/tlb_slot_allocator.sv
// tlb_slot_allocator: TLB fill slot allocation with free list and round-robin replacement.
// Each item passes through the input register and then the result register.
// Throughput: one item per cycle while out_stall is low; match, priority select and
// free-list head update all settle between the input and result registers.
// Reset (rst_n, synchronous): all entries invalid, free list 0..ENTRIES-1, pointer 0,
// no items in flight. Depends on tsa_pkg, tsa_cam, tsa_free_list.
module tlb_slot_allocator import tsa_pkg::*; #(
  parameter int ENTRIES          = DEF_ENTRIES,
  parameter int PAGE_NUMBER_BITS = DEF_PAGE_NUMBER_BITS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // input items
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [REQ_W-1:0]            in_req_type,
  input  logic [PAGE_NUMBER_BITS-1:0] in_vpage,
  input  logic [PAGE_NUMBER_BITS-1:0] in_ppage,
  input  logic                        in_dirty,
  // result items
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [SLOT_W-1:0]           out_slot,
  output logic [OUTCOME_W-1:0]        out_outcome
);

  localparam int IW = $clog2(ENTRIES);

  // Input register
  logic                        s1_valid_r;
  logic [REQ_W-1:0]            s1_req_r;
  logic [PAGE_NUMBER_BITS-1:0] s1_vpage_r;
  logic [PAGE_NUMBER_BITS-1:0] s1_ppage_r;
  logic                        s1_dirty_r;

  // Result register
  logic                        out_valid_r;
  logic [SLOT_W-1:0]           out_slot_r,    out_slot_nxt;
  logic [OUTCOME_W-1:0]        out_outcome_r, out_outcome_nxt;

  logic [IW-1:0] rr_r, rr_nxt;

  logic          advance;
  logic          fire;
  logic          is_flush;
  logic          is_add;
  logic          is_inval;

  logic          cam_hit;
  logic [IW-1:0] cam_hit_idx;
  logic          cam_wr;
  logic [IW-1:0] cam_wr_idx;
  logic          cam_clr;
  logic          fl_nonempty;
  logic [IW-1:0] fl_head;
  fl_cmd_t       fl_cmd;

  // Handshake
  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !advance;
  assign fire     = s1_valid_r && advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_req_r   <= in_req_type;
      s1_vpage_r <= in_vpage;
      s1_ppage_r <= in_ppage;
      s1_dirty_r <= in_dirty;
    end
  end

  // Request decode
  assign is_flush = s1_req_r[REQ_W-1];
  assign is_add   = (s1_req_r == REQ_ADD);
  assign is_inval = (s1_req_r == REQ_INVAL);

  // Slot choice and outcome
  always_comb begin
    rr_nxt          = rr_r;
    cam_wr          = 1'b0;
    cam_clr         = 1'b0;
    cam_wr_idx      = fl_head;
    fl_cmd          = '0;
    out_slot_nxt    = '0;
    out_outcome_nxt = OUT_FLUSHED;
    if (is_flush) begin
      fl_cmd.flush    = fire;
      out_outcome_nxt = OUT_FLUSHED;
    end else if (is_add) begin
      cam_wr = fire;
      if (fl_nonempty) begin
        cam_wr_idx      = fl_head;
        fl_cmd.pop      = fire;
        out_outcome_nxt = OUT_ADD_FREE;
      end else begin
        cam_wr_idx      = rr_r;
        out_outcome_nxt = OUT_ADD_REPL;
        if (fire) begin
          rr_nxt = (rr_r == IW'(ENTRIES - 1)) ? '0 : rr_r + IW'(1);
        end
      end
      out_slot_nxt = SLOT_W'(cam_wr_idx);
    end else if (is_inval) begin
      if (cam_hit) begin
        cam_clr         = fire;
        fl_cmd.push     = fire;
        out_slot_nxt    = SLOT_W'(cam_hit_idx);
        out_outcome_nxt = OUT_INVAL_HIT;
      end else begin
        out_outcome_nxt = OUT_INVAL_MISS;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rr_r <= '0;
    end else begin
      rr_r <= rr_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_slot_r    <= out_slot_nxt;
      out_outcome_r <= out_outcome_nxt;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_slot    = out_slot_r;
  assign out_outcome = out_outcome_r;

  tsa_cam #(
    .ENTRIES          (ENTRIES),
    .PAGE_NUMBER_BITS (PAGE_NUMBER_BITS)
  ) u_cam (
    .clk          (clk),
    .rst_n        (rst_n),
    .lookup_vpage (s1_vpage_r),
    .hit          (cam_hit),
    .hit_idx      (cam_hit_idx),
    .wr_en        (cam_wr),
    .wr_idx       (cam_wr_idx),
    .wr_vpage     (s1_vpage_r),
    .wr_ppage     (s1_ppage_r),
    .wr_dirty     (s1_dirty_r),
    .clr_en       (cam_clr),
    .clr_idx      (cam_hit_idx),
    .flush        (fl_cmd.flush)
  );

  tsa_free_list #(
    .ENTRIES (ENTRIES)
  ) u_free_list (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (fl_cmd),
    .push_slot (cam_hit_idx),
    .nonempty  (fl_nonempty),
    .head      (fl_head)
  );

endmodule
